[sv/sha_pkg.sv]
// ----------------------------------------------------------------------------
// SHA-256 package
// Round constants, initial hash values, the rotate helper function and the
// command/status types shared by the controller and the datapath.
// ----------------------------------------------------------------------------
package sha_pkg;

    localparam logic [31:0] H_INIT [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam int unsigned LEN_BYTES = 9;

    // datapath commands
    typedef struct packed {
        logic       wr_byte;    // store input byte at fill position
        logic       wr_pad;     // store pad/zero/length byte at r_pos
        logic       pos_clr;    // reset pad position to fill count
        logic       pos_zero;   // reset pad position to zero
        logic       pos_inc;
        logic       rnd_start;  // load working vars, clear round count
        logic       rnd_step;   // one compression round
        logic       rnd_fold;   // add working vars into hash
        logic       out_shift;  // rotate hash words for output
        logic       msg_clr;    // back to initial state
    } t_dp_cmd;

    typedef struct packed {
        logic       fill_full;  // 63 bytes held before the write
        logic       over_55;    // fill count above 55
        logic       pos_last;   // pad position is 63
        logic       rnd_done;   // round 63 in progress
    } t_dp_sts;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

endpackage

[sv/sha256_stream_hasher.sv]
// ----------------------------------------------------------------------------
// SHA-256 stream hasher
// Hashes a byte stream per FIPS 180-4 and returns the eight digest words.
//
// channel | dir | tdata                  | tuser       | tlast
// s_axis  | in  | [7:0] data_byte        | byte_valid  | last
// m_axis  | out | [31:0] digest_word     | word_index  | last_word
//
// The 64th byte of a block starts the rounds of the single compression round
// unit, followed by a fold into the hash words.
// Closing a message pads the block at one byte per cycle, then one or two
// compressions, then eight output words.
// Input is not accepted while padding, compressing or emitting the digest.
// Reset is synchronous, active low; the block store needs no clearing.
// ----------------------------------------------------------------------------
module sha256_stream_hasher (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] byte_valid
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] digest_word
    output logic [2:0]  m_axis_tuser,   // [2:0] word_index
    output logic        m_axis_tlast
);

    sha_pkg::t_dp_cmd w_cmd;
    sha_pkg::t_dp_sts w_sts;
    logic [2:0]       w_idx;

    sha_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .i_byte_valid (s_axis_tuser),
        .i_last       (s_axis_tlast),
        .i_out_ready  (m_axis_tready),
        .i_sts        (w_sts),
        .o_in_ready   (s_axis_tready),
        .o_out_valid  (m_axis_tvalid),
        .o_word_index (w_idx),
        .o_cmd        (w_cmd)
    );

    sha_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_data_byte   (s_axis_tdata),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .o_digest_word (m_axis_tdata)
    );

    assign m_axis_tuser = w_idx;
    assign m_axis_tlast = (w_idx == 3'd7);

endmodule

[sv/sha_ctrl.sv]
// ----------------------------------------------------------------------------
// SHA-256 controller
// Sequences byte loading, padding, compression rounds and digest output.
// ----------------------------------------------------------------------------
module sha_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_byte_valid,
    input  logic             i_last,
    input  logic             i_out_ready,
    input  sha_pkg::t_dp_sts i_sts,
    output logic             o_in_ready,
    output logic             o_out_valid,
    output logic [2:0]       o_word_index,
    output sha_pkg::t_dp_cmd o_cmd
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_PAD   = 6'b000010,
        S_PAD2  = 6'b000100,
        S_RND   = 6'b001000,
        S_FOLD  = 6'b010000,
        S_OUT   = 6'b100000
    } t_state;

    t_state     r_state, n_state;
    logic       r_closing, n_closing;   // message closing after this block
    logic       r_second, n_second;     // a length block still follows
    logic [2:0] r_idx, n_idx;

    assign o_in_ready   = (r_state == S_IDLE);
    assign o_out_valid  = (r_state == S_OUT);
    assign o_word_index = r_idx;

    always_comb begin
        n_state   = r_state;
        n_closing = r_closing;
        n_second  = r_second;
        n_idx     = r_idx;
        o_cmd     = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.wr_byte = i_byte_valid;
                    n_closing     = i_last;
                    if (i_byte_valid && i_sts.fill_full) begin
                        o_cmd.rnd_start = 1'b1;
                        o_cmd.pos_zero  = 1'b1;
                        n_second        = 1'b0;
                        n_state         = S_RND;
                    end else if (i_last) begin
                        o_cmd.pos_clr = 1'b1;
                        n_state       = S_PAD;
                    end
                end
            end
            S_PAD: begin
                o_cmd.wr_pad  = 1'b1;
                o_cmd.pos_inc = 1'b1;
                if (i_sts.pos_last) begin
                    o_cmd.rnd_start = 1'b1;
                    n_second        = i_sts.over_55;
                    n_state         = S_RND;
                end
            end
            S_PAD2: begin
                o_cmd.wr_pad  = 1'b1;
                o_cmd.pos_inc = 1'b1;
                if (i_sts.pos_last) begin
                    o_cmd.rnd_start = 1'b1;
                    n_second        = 1'b0;
                    n_state         = S_RND;
                end
            end
            S_RND: begin
                o_cmd.rnd_step = 1'b1;
                if (i_sts.rnd_done) begin
                    n_state = S_FOLD;
                end
            end
            S_FOLD: begin
                o_cmd.rnd_fold = 1'b1;
                if (r_second) begin
                    o_cmd.pos_zero = 1'b1;
                    n_state        = S_PAD2;
                end else if (r_closing) begin
                    o_cmd.pos_clr = 1'b1;
                    n_state       = S_PAD;
                    n_closing     = 1'b0;
                    n_idx         = 3'd0;
                    // pad only if closing was deferred by a full block
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_OUT: begin
                if (i_out_ready) begin
                    o_cmd.out_shift = 1'b1;
                    n_idx           = r_idx + 3'd1;
                    if (r_idx == 3'd7) begin
                        o_cmd.msg_clr = 1'b1;
                        n_state       = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // track whether the current compression is the final one
    logic r_final, n_final;
    always_comb begin
        n_final = r_final;
        if (r_state == S_IDLE) begin
            n_final = 1'b0;
        end
        if ((r_state == S_PAD || r_state == S_PAD2) && i_sts.pos_last) begin
            n_final = !(r_state == S_PAD && i_sts.over_55);
        end
    end

    t_state n_state_f;
    always_comb begin
        n_state_f = n_state;
        if (r_state == S_FOLD && r_final) begin
            n_state_f = S_OUT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_closing <= 1'b0;
            r_second  <= 1'b0;
            r_final   <= 1'b0;
            r_idx     <= 3'd0;
        end else begin
            r_state   <= n_state_f;
            r_closing <= (r_state == S_FOLD && r_final) ? 1'b0 : n_closing;
            r_second  <= n_second;
            r_final   <= n_final;
            r_idx     <= (r_state == S_FOLD) ? 3'd0 : n_idx;
        end
    end

`ifndef SYNTHESIS
    a_out_only_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FOLD && !r_final) |=> (r_state != S_OUT))
        else $error("digest output without final block");
    a_idx_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && i_out_ready && r_idx == 3'd7) |=> (r_state == S_IDLE))
        else $error("output did not end after word 7");
    a_rnd_to_fold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RND && i_sts.rnd_done) |=> (r_state == S_FOLD))
        else $error("rounds did not end in fold");
`endif

endmodule

[sv/sha_dpath.sv]
// ----------------------------------------------------------------------------
// SHA-256 datapath
// Block bytes shift into the message schedule window, one-round-per-cycle
// compression, hash words, byte count and padding byte generation.
// ----------------------------------------------------------------------------
module sha_dpath (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [7:0]       i_data_byte,
    input  sha_pkg::t_dp_cmd i_cmd,
    output sha_pkg::t_dp_sts o_sts,
    output logic [31:0]      o_digest_word
);

    logic [5:0]  r_fill;
    logic [5:0]  r_pos;
    logic [60:0] r_total;
    logic [31:0] r_h [8];
    logic [31:0] r_v [8];
    logic [31:0] r_w [16];
    logic [5:0]  r_rnd;
    logic [63:0] w_bits;
    logic [7:0]  w_pad;
    logic [7:0]  w_in_byte;
    logic [31:0] w_wt, w_wnew, w_s0, w_s1, w_t1, w_t2;

    assign w_bits = {r_total, 3'b000};
    assign o_sts.fill_full = (r_fill == 6'd63);
    assign o_sts.over_55   = (r_fill > 6'(64 - sha_pkg::LEN_BYTES));
    assign o_sts.pos_last  = (r_pos == 6'd63);
    assign o_sts.rnd_done  = (r_rnd == 6'd63);
    assign o_digest_word   = r_h[0];

    // pad byte at r_pos: 0x80 at fill position (first pass only), length at
    // the tail unless the block overflows, zeros elsewhere
    logic r_pad_first;
    always_comb begin
        w_pad = 8'h00;
        if (r_pad_first && r_pos == r_fill) begin
            w_pad = sha_pkg::PAD_BYTE;
        end else if (r_pos >= 6'd56 && !(r_pad_first && o_sts.over_55)) begin
            w_pad = w_bits[8 * (7 - r_pos[2:0]) +: 8];
        end
    end

    // round-sequential schedule: window slides by one each round
    assign w_wt   = r_w[0];
    assign w_s0   = sha_pkg::rotr(r_w[1], 7) ^ sha_pkg::rotr(r_w[1], 18) ^ (r_w[1] >> 3);
    assign w_s1   = sha_pkg::rotr(r_w[14], 17) ^ sha_pkg::rotr(r_w[14], 19)
                    ^ (r_w[14] >> 10);
    assign w_wnew = r_w[0] + w_s0 + r_w[9] + w_s1;
    assign w_t1   = r_v[7] + (sha_pkg::rotr(r_v[4], 6) ^ sha_pkg::rotr(r_v[4], 11)
                    ^ sha_pkg::rotr(r_v[4], 25))
                    + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6])) + sha_pkg::ROUND_K[r_rnd] + w_wt;
    assign w_t2   = (sha_pkg::rotr(r_v[0], 2) ^ sha_pkg::rotr(r_v[0], 13)
                    ^ sha_pkg::rotr(r_v[0], 22))
                    + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));

    // each block gets exactly 64 byte writes in order, shifted in at the tail
    assign w_in_byte = i_cmd.wr_byte ? i_data_byte : w_pad;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_byte || i_cmd.wr_pad) begin
            for (int t = 0; t < 15; t++) begin
                r_w[t] <= {r_w[t][23:0], r_w[t + 1][31:24]};
            end
            r_w[15] <= {r_w[15][23:0], w_in_byte};
        end else if (i_cmd.rnd_step) begin
            for (int t = 0; t < 15; t++) begin
                r_w[t] <= r_w[t + 1];
            end
            r_w[15] <= w_wnew;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rnd_start) begin
            for (int t = 0; t < 8; t++) begin
                r_v[t] <= r_h[t];
            end
        end else if (i_cmd.rnd_step) begin
            r_v[0] <= w_t1 + w_t2;
            r_v[1] <= r_v[0];
            r_v[2] <= r_v[1];
            r_v[3] <= r_v[2];
            r_v[4] <= r_v[3] + w_t1;
            r_v[5] <= r_v[4];
            r_v[6] <= r_v[5];
            r_v[7] <= r_v[6];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= 6'd0;
            r_pos       <= 6'd0;
            r_total     <= '0;
            r_rnd       <= 6'd0;
            r_pad_first <= 1'b1;
            for (int t = 0; t < 8; t++) begin
                r_h[t] <= sha_pkg::H_INIT[t];
            end
        end else begin
            if (i_cmd.wr_byte) begin
                r_fill  <= r_fill + 6'd1;
                r_total <= r_total + 61'd1;
            end
            if (i_cmd.pos_clr) begin
                r_pos       <= r_fill + {5'd0, i_cmd.wr_byte};
                r_pad_first <= 1'b1;
            end else if (i_cmd.pos_zero) begin
                r_pos       <= 6'd0;
                r_pad_first <= !i_cmd.rnd_start ? 1'b0 : 1'b1;
            end else if (i_cmd.pos_inc) begin
                r_pos <= r_pos + 6'd1;
            end
            if (i_cmd.rnd_start) begin
                r_rnd <= 6'd0;
            end else if (i_cmd.rnd_step) begin
                r_rnd <= r_rnd + 6'd1;
            end
            if (i_cmd.rnd_fold) begin
                for (int t = 0; t < 8; t++) begin
                    r_h[t] <= r_h[t] + r_v[t];
                end
            end else if (i_cmd.out_shift) begin
                for (int t = 0; t < 7; t++) begin
                    r_h[t] <= r_h[t + 1];
                end
                r_h[7] <= r_h[0];
            end
            if (i_cmd.msg_clr) begin
                r_fill      <= 6'd0;
                r_total     <= '0;
                r_pad_first <= 1'b1;
                for (int t = 0; t < 8; t++) begin
                    r_h[t] <= sha_pkg::H_INIT[t];
                end
            end
        end
    end

`ifndef SYNTHESIS
    a_no_dual_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.wr_byte && i_cmd.wr_pad))
        else $error("byte and pad write together");
    a_rnd_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.rnd_step && !i_cmd.rnd_start) |=> (r_rnd == $past(r_rnd) + 6'd1))
        else $error("round counter slip");
    a_fill_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.wr_byte && r_fill == 6'd63) |=> (r_fill == 6'd0))
        else $error("fill count did not wrap on full block");
`endif

endmodule
